/* rtl/tks_pkg.sv */
package tks_pkg;
  localparam int MAX_KEEP = 64;
  localparam int MAX_ROW = 65536;
  localparam int KW = $clog2(MAX_KEEP + 1);
  localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam logic [15:0] POS_TOP = 16'(((MAX_ROW - 1) < 65535) ? (MAX_ROW - 1) : 65535);

  localparam logic [1:0] REG_KEEP = 2'd0;
  localparam logic [1:0] REG_LARGEST = 2'd1;
  localparam logic [1:0] REG_ORDER = 2'd2;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] pos;
  } entry_t;

  // Cell control broadcast along the chain.
  typedef struct packed {
    logic       insert;
    logic       largest;
    logic [KW-1:0] k;
    entry_t     item;
  } ctl_t;

  // Float compare a better than b (NaN never better).
  function automatic logic better(input logic [31:0] a, input logic [31:0] b,
                                  input logic largest);
    logic an, bn, gt, lt, az;
    an = (a[30:23] == 8'hff) && (a[22:0] != 0);
    bn = (b[30:23] == 8'hff) && (b[22:0] != 0);
    az = (a[30:0] == 0) && (b[30:0] == 0);
    if (a[31] != b[31]) begin
      gt = !a[31];
    end else if (!a[31]) begin
      gt = a[30:0] > b[30:0];
    end else begin
      gt = a[30:0] < b[30:0];
    end
    lt = !gt && (a != b) && !az;
    if (an || bn || az) begin
      better = 1'b0;
    end else begin
      better = largest ? gt : lt;
    end
  endfunction
endpackage

/* rtl/topk_select_sort.sv */
// Each accepted element is registered into the insertion chain; one element per cycle,
// except during emit. A row-last beat is followed by an emit phase of n beats: in rank
// order one per cycle while out_ready is high; in position order each beat waits for a
// scan of the n kept entries. Input is held off during emit. rst_n is synchronous,
// active low; it clears the chain valid bits, row counters and restores keep_count=1,
// largest, by value.
module topk_select_sort import tks_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_value,
  input  logic        in_row_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_best_value,
  output logic [15:0] out_best_position,
  output logic        out_final_result,
  output logic        out_row_overflow,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [6:0] keep_r;
  logic largest_r, order_r;
  logic [15:0] pos_r;
  logic full_r, ovf_r;
  logic emit_r;
  logic [KW-1:0] n_r, sent_r;
  logic [MAX_KEEP-1:0] done_r;
  logic [IW-1:0] scan_r, bsel_r;
  logic bfound_r, pick_ok_r;
  logic [KW-1:0] k_eff;
  logic [KW-1:0] n_now;
  ctl_t ctl;
  logic [MAX_KEEP-1:0] take, valid;
  entry_t ent [MAX_KEEP];
  logic accept, clear;
  logic [IW-1:0] sel;

  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[3:2])
      REG_KEEP:    cfg_prdata = {25'd0, keep_r};
      REG_LARGEST: cfg_prdata = {31'd0, largest_r};
      REG_ORDER:   cfg_prdata = {31'd0, order_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (keep_r == 0) k_eff = KW'(1);
    else if ({1'b0, keep_r} > 8'(MAX_KEEP)) k_eff = KW'(MAX_KEEP);
    else k_eff = KW'(keep_r);
  end

  assign in_ready = !emit_r;
  assign accept = in_valid && in_ready;
  assign ctl.insert = accept;
  assign ctl.largest = largest_r;
  assign ctl.k = k_eff;
  assign ctl.item.value = in_sample_value;
  assign ctl.item.pos = pos_r;

  genvar g;
  for (g = 0; g < MAX_KEEP; g++) begin : g_cell
    if (g == 0) begin : g_head
      tks_cell u_cell (.clk, .rst_n, .idx(IW'(g)), .ctl, .clear,
        .left_valid(1'b0), .left_entry(ent[0]), .left_take(1'b0),
        .take(take[g]), .valid(valid[g]), .entry(ent[g]));
    end else begin : g_body
      tks_cell u_cell (.clk, .rst_n, .idx(IW'(g)), .ctl, .clear,
        .left_valid(valid[g-1]), .left_entry(ent[g-1]), .left_take(take[g-1]),
        .take(take[g]), .valid(valid[g]), .entry(ent[g]));
    end
  end

  // Kept entries before the current element; it always enters while the list
  // is short of k.
  assign n_now = KW'($countones(valid));

  // Output selection: rank order takes the next slot; position order takes the
  // smallest unsent position found by the scan (lowest rank on ties).
  assign sel = order_r ? IW'(sent_r) : bsel_r;

  assign out_valid = emit_r && (order_r || pick_ok_r);
  assign out_best_value = ent[sel].value;
  assign out_best_position = ent[sel].pos;
  assign out_final_result = (sent_r + 1'b1) == n_r;
  assign out_row_overflow = ovf_r;
  assign clear = out_valid && out_ready && out_final_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= 7'd1; largest_r <= 1'b1; order_r <= 1'b1;
      pos_r <= '0; full_r <= 1'b0; ovf_r <= 1'b0; emit_r <= 1'b0;
      n_r <= '0; sent_r <= '0; done_r <= '0;
      scan_r <= '0; bsel_r <= '0; bfound_r <= 1'b0; pick_ok_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[3:2])
          REG_KEEP:    keep_r <= cfg_pwdata[6:0];
          REG_LARGEST: largest_r <= cfg_pwdata[0];
          REG_ORDER:   order_r <= cfg_pwdata[0];
          default:     ;
        endcase
      end
      if (accept) begin
        if (full_r) ovf_r <= 1'b1;
        else if (pos_r >= POS_TOP) full_r <= 1'b1;
        else pos_r <= pos_r + 16'd1;
        if (in_row_last) begin
          emit_r <= 1'b1;
          n_r <= (n_now < k_eff) ? n_now + KW'(1) : n_now;
          sent_r <= '0;
          done_r <= '0;
          scan_r <= '0;
          bfound_r <= 1'b0;
          pick_ok_r <= 1'b0;
        end
      end
      // One kept entry is examined per cycle until the whole list is seen.
      if (emit_r && !order_r && !pick_ok_r) begin
        if (!done_r[scan_r] && (!bfound_r || ent[scan_r].pos < ent[bsel_r].pos)) begin
          bsel_r <= scan_r;
          bfound_r <= 1'b1;
        end
        if ((KW'(scan_r) + KW'(1)) == n_r) pick_ok_r <= 1'b1;
        else scan_r <= scan_r + 1'b1;
      end
      if (out_valid && out_ready) begin
        sent_r <= sent_r + 1'b1;
        done_r[sel] <= 1'b1;
        scan_r <= '0;
        bfound_r <= 1'b0;
        pick_ok_r <= 1'b0;
        if (out_final_result) begin
          emit_r <= 1'b0; pos_r <= '0; full_r <= 1'b0; ovf_r <= 1'b0;
        end
      end
    end
  end
endmodule

/* rtl/tks_cell.sv */
module tks_cell import tks_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] idx,
  input  ctl_t          ctl,
  input  logic          clear,
  input  logic          left_valid,
  input  entry_t        left_entry,
  input  logic          left_take,
  output logic          take,
  output logic          valid,
  output entry_t        entry
);
  logic   valid_r;
  entry_t entry_r;
  logic   active;
  assign active = ({1'b0, idx} < ctl.k);
  assign take = active && ctl.insert &&
                (!valid_r || better(ctl.item.value, entry_r.value, ctl.largest));
  assign valid = valid_r && active;
  assign entry = entry_r;

  // A cell past the kept count drops its entry only when an element arrives or the row
  // is cleared, so a lowered and raised count between elements keeps the list intact.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= 1'b0;
    end else if (ctl.insert && !active) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= left_take ? left_valid : 1'b1;
      entry_r <= left_take ? left_entry : ctl.item;
    end
  end
endmodule

/* tb/tb_topk_select_sort.sv */
module tb_topk_select_sort;
  import tks_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic [15:0] pos;
    logic        fin;
    logic        ovf;
  } pick_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_sample_value;
  logic        in_row_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_best_value;
  logic [15:0] out_best_position;
  logic        out_final_result;
  logic        out_row_overflow;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow configuration and selection state.
  logic [6:0]  sh_keep;
  logic        sh_largest;
  logic        sh_by_value;
  logic [31:0] sel_values [MAX_KEEP];
  logic [15:0] sel_positions [MAX_KEEP];
  int          sel_count;
  int          row_pos;
  bit          row_full;
  bit          row_ovf;

  pick_t       picks_due [$];
  int          errors;
  bit          in_stall_on;
  bit          out_stall_on;

  topk_select_sort DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("tb_topk_select_sort failed");
    $finish;
  end

  // Total order on float bit patterns; both zeros fold onto one key.
  function automatic logic [31:0] order_key(input logic [31:0] b);
    logic [31:0] m;
    m = (b[30:0] == 31'd0) ? 32'd0 : b;
    return m[31] ? ~m : (m | 32'h8000_0000);
  endfunction

  function automatic bit is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
  endfunction

  function automatic bit outranks(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    return sh_largest ? (order_key(a) > order_key(b)) : (order_key(a) < order_key(b));
  endfunction

  task automatic predict_beat(input logic [31:0] v, input logic last);
    int k;
    int slot;
    int pos;
    int i;
    int j;
    logic [31:0] ov [MAX_KEEP];
    logic [15:0] op [MAX_KEEP];
    logic [31:0] tv;
    logic [15:0] tp;
    pick_t e;
    pos = row_pos;
    if (row_full) row_ovf = 1'b1;
    else if (row_pos >= int'(POS_TOP)) row_full = 1'b1;
    else row_pos++;
    k = (sh_keep == 0) ? 1 : ((sh_keep > MAX_KEEP) ? MAX_KEEP : sh_keep);
    if (sel_count > k) sel_count = k;
    slot = MAX_KEEP;
    if (sel_count < k) begin
      slot = sel_count;
      sel_count++;
    end else if (outranks(v, sel_values[k-1])) begin
      slot = k - 1;
    end
    if (slot < MAX_KEEP) begin
      while (slot > 0 && outranks(v, sel_values[slot-1])) begin
        sel_values[slot] = sel_values[slot-1];
        sel_positions[slot] = sel_positions[slot-1];
        slot--;
      end
      sel_values[slot] = v;
      sel_positions[slot] = 16'(pos);
    end
    if (last) begin
      for (i = 0; i < sel_count; i++) begin
        ov[i] = sel_values[i];
        op[i] = sel_positions[i];
      end
      if (!sh_by_value) begin
        for (i = 1; i < sel_count; i++) begin
          tv = ov[i];
          tp = op[i];
          j = i;
          while (j > 0 && op[j-1] > tp) begin
            ov[j] = ov[j-1];
            op[j] = op[j-1];
            j--;
          end
          ov[j] = tv;
          op[j] = tp;
        end
      end
      for (i = 0; i < sel_count; i++) begin
        e.value = ov[i];
        e.pos = op[i];
        e.fin = (i == sel_count - 1);
        e.ovf = row_ovf;
        picks_due.push_back(e);
      end
      sel_count = 0;
      row_pos = 0;
      row_full = 1'b0;
      row_ovf = 1'b0;
    end
  endtask

  // Returns right after the accepting edge with in_valid still high.
  task automatic send_beat(input logic [31:0] v, input logic last);
    int gap;
    gap = in_stall_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= v;
    in_row_last <= last;
    do @(posedge clk); while (!in_ready);
    predict_beat(v, last);
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    hold_input();
    while (picks_due.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_KEEP:    sh_keep = data[6:0];
      REG_LARGEST: sh_largest = data[0];
      REG_ORDER:   sh_by_value = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: return 32'h3f80_0000 + $urandom_range(0, 3);
      5: return 32'hbf80_0000 + $urandom_range(0, 3);
      6: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'h8000_0000;
      7: return $urandom_range(0, 1) ? 32'h7f80_0000 : 32'hff80_0000;
      default: return {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 15) << 23)};
    endcase
  endfunction

  task automatic send_row(input int len);
    int i;
    for (i = 0; i < len; i++) send_beat(pick_value(), i == len - 1);
  endtask

  task automatic test_defaults();
    send_beat(32'h4000_0000, 1'b0);
    send_beat(32'h4040_0000, 1'b0);
    send_beat(32'h4040_0000, 1'b1);
    send_beat(32'hc000_0000, 1'b1);
    drain();
  endtask

  task automatic test_extremes();
    write_reg(REG_KEEP, 32'd4);
    write_reg(REG_LARGEST, 32'd0);
    write_reg(REG_ORDER, 32'd0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h7f80_0000, 1'b0);
    send_beat(32'hff80_0000, 1'b0);
    send_beat(32'h7fff_ffff, 1'b0);
    send_beat(32'hffff_ffff, 1'b0);
    send_beat(32'h0000_0001, 1'b1);
    drain();
    write_reg(REG_LARGEST, 32'd1);
    write_reg(REG_KEEP, 32'd0);
    send_beat(32'h7f7f_ffff, 1'b0);
    send_beat(32'h7f7f_ffff, 1'b1);
    send_beat(32'hffff_ffff, 1'b1);
    drain();
  endtask

  task automatic test_midrow();
    write_reg(REG_KEEP, 32'd5);
    write_reg(REG_ORDER, 32'd1);
    send_row(0);
    repeat (6) send_beat(pick_value(), 1'b0);
    drain();
    write_reg(REG_KEEP, 32'd2);
    repeat (2) send_beat(pick_value(), 1'b0);
    drain();
    write_reg(REG_LARGEST, 32'd0);
    write_reg(REG_ORDER, 32'd0);
    send_beat(pick_value(), 1'b0);
    send_beat(pick_value(), 1'b1);
    drain();
  endtask

  // A row far longer than the full list, emitted in position order, back to back.
  task automatic test_long_row();
    bit save_in;
    bit save_out;
    save_in = in_stall_on;
    save_out = out_stall_on;
    in_stall_on = 1'b0;
    out_stall_on = 1'b0;
    write_reg(REG_KEEP, 32'd64);
    write_reg(REG_LARGEST, 32'd1);
    write_reg(REG_ORDER, 32'd0);
    send_row(100);
    drain();
    in_stall_on = save_in;
    out_stall_on = save_out;
  endtask

  task automatic test_random(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        case ($urandom_range(0, 9))
          0: write_reg(REG_KEEP, 32'd64);
          1: write_reg(REG_KEEP, 32'($urandom_range(65, 127)));
          2: write_reg(REG_KEEP, 32'd0);
          default: write_reg(REG_KEEP, 32'($urandom_range(1, 8)));
        endcase
        write_reg(REG_LARGEST, 32'($urandom_range(0, 1)));
        write_reg(REG_ORDER, 32'($urandom_range(0, 1)));
        in_stall_on = $urandom_range(0, 2) != 0;
        out_stall_on = $urandom_range(0, 2) != 0;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
      send_row(len);
      sent += len;
    end
    drain();
  endtask

  initial begin
    forever begin
      int gap;
      gap = out_stall_on ? $urandom_range(0, 11) : 0;
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    pick_t e;
    if (rst_n && out_valid && out_ready) begin
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected result beat value %h pos %0d", $time,
                 out_best_value, out_best_position);
        errors++;
      end else begin
        e = picks_due.pop_front();
        if (out_best_value !== e.value) begin
          $display("%0t: value expected %h actual %h", $time, e.value, out_best_value);
          errors++;
        end
        if (out_best_position !== e.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, e.pos,
                   out_best_position);
          errors++;
        end
        if (out_final_result !== e.fin) begin
          $display("%0t: final expected %b actual %b", $time, e.fin, out_final_result);
          errors++;
        end
        if (out_row_overflow !== e.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, e.ovf, out_row_overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    in_stall_on = 1'b1;
    out_stall_on = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_value = 32'd0;
    in_row_last = 1'b0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 4'd0;
    cfg_pwdata = 32'd0;
    sh_keep = 7'd1;
    sh_largest = 1'b1;
    sh_by_value = 1'b1;
    sel_count = 0;
    row_pos = 0;
    row_full = 1'b0;
    row_ovf = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_extremes();
    test_midrow();
    test_long_row();
    test_random(300);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("tb_topk_select_sort passed");
    end else begin
      $display("tb_topk_select_sort failed");
    end
    $finish;
  end
endmodule

/* topk_select_sort.f */
rtl/tks_pkg.sv
rtl/tks_cell.sv
rtl/topk_select_sort.sv
tb/tb_topk_select_sort.sv
